@@ design/nplm_pkg.sv @@
// Shared types and constants for the NAND plane latency model.
`timescale 1ns / 1ps
package nplm_pkg;

  localparam int unsigned DELAY_W     = 24;
  localparam int unsigned FIELD_TIME_W = 48;
  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IDX_MAX_W   = 12;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ0  = 3'd0,
    REG_WRITE0 = 3'd1,
    REG_ERASE0 = 3'd2,
    REG_READ1  = 3'd3,
    REG_WRITE1 = 3'd4,
    REG_ERASE1 = 3'd5
  } cfg_reg_e;

  localparam logic [DELAY_W-1:0] CFG_RESET [NUM_REGS] = '{
    24'd40000, 24'd200000, 24'd2000000,
    24'd40000, 24'd200000, 24'd2000000
  };

  typedef struct packed {
    op_e                     op;
    logic [2:0]              channel;
    logic [1:0]              lun;
    logic                    plane_sel;
    logic                    cell_type;
    logic [FIELD_TIME_W-1:0] request_time;
    logic [FIELD_TIME_W-1:0] current_time;
    logic                    first_page;
    logic                    last_page;
  } in_t;

  typedef struct packed {
    logic [FIELD_TIME_W-1:0] latency;
    logic [FIELD_TIME_W-1:0] request_max_latency;
    logic                    request_done;
  } out_t;

  // Classified page command handed from front to back.
  typedef struct packed {
    logic                    active;
    logic [IDX_MAX_W-1:0]    idx;
    logic [FIELD_TIME_W-1:0] req;
    logic [DELAY_W-1:0]      delay;
    logic                    first;
    logic                    last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ design/nplm_ram.sv @@
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps
module nplm_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/nplm_queue.sv @@
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
module nplm_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  nplm_pkg::cmd_t          push_data_i,
  input  logic                    pop_i,
  output nplm_pkg::cmd_t          head_o,
  output nplm_pkg::queue_status_t status_o
);

  nplm_pkg::cmd_t                       entry_q [nplm_pkg::QUEUE_DEPTH];
  logic [nplm_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [nplm_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [nplm_pkg::QUEUE_CNT_W-1:0]     cnt_q, cnt_d;
  logic                                 do_push, do_pop;

  assign status_o.full  = (cnt_q == nplm_pkg::QUEUE_CNT_W'(nplm_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/nplm_front.sv @@
// Front end: delay registers, input acceptance and page classification.
`timescale 1ns / 1ps
module nplm_front #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned LUNS      = 4,
  parameter int unsigned PLANES    = 2,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nplm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nplm_pkg::DELAY_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  nplm_pkg::in_t                     in_data_i,
  input  logic                              clearing_i,
  input  nplm_pkg::queue_status_t           queue_status_i,
  output logic                              push_o,
  output nplm_pkg::cmd_t                    cmd_o
);

  localparam int unsigned ReqW = (TIME_BITS < nplm_pkg::FIELD_TIME_W) ?
                                 TIME_BITS : nplm_pkg::FIELD_TIME_W;
  localparam logic [nplm_pkg::FIELD_TIME_W-1:0] ReqMask =
    (ReqW == nplm_pkg::FIELD_TIME_W) ? '1 :
    ((nplm_pkg::FIELD_TIME_W'(1) << ReqW) - nplm_pkg::FIELD_TIME_W'(1));

  logic [nplm_pkg::DELAY_W-1:0]      cfg_q [nplm_pkg::NUM_REGS];
  logic [nplm_pkg::FIELD_TIME_W-1:0] req_in, now_in;
  logic                              addr_ok;
  nplm_pkg::cfg_reg_e                delay_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= nplm_pkg::CFG_RESET;
    end else if (cfg_we_i && (cfg_index_i < nplm_pkg::CFG_IDX_W'(nplm_pkg::NUM_REGS))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign in_stall_o = clearing_i || queue_status_i.full;
  assign push_o     = in_valid_i && !in_stall_o;

  assign req_in  = in_data_i.request_time & ReqMask;
  assign now_in  = in_data_i.current_time & ReqMask;
  assign addr_ok = (int'(in_data_i.channel) < CHANNELS) &&
                   (int'(in_data_i.lun) < LUNS) &&
                   (int'(in_data_i.plane_sel) < PLANES);

  always_comb begin
    unique case (in_data_i.op)
      nplm_pkg::OP_READ:  delay_sel = in_data_i.cell_type ? nplm_pkg::REG_READ1
                                                          : nplm_pkg::REG_READ0;
      nplm_pkg::OP_WRITE: delay_sel = in_data_i.cell_type ? nplm_pkg::REG_WRITE1
                                                          : nplm_pkg::REG_WRITE0;
      nplm_pkg::OP_ERASE: delay_sel = in_data_i.cell_type ? nplm_pkg::REG_ERASE1
                                                          : nplm_pkg::REG_ERASE0;
      default:            delay_sel = nplm_pkg::REG_READ0;
    endcase
  end

  always_comb begin
    cmd_o.active = (in_data_i.op != nplm_pkg::OP_NONE) && addr_ok;
    cmd_o.idx    = nplm_pkg::IDX_MAX_W'((int'(in_data_i.channel) * LUNS +
                                         int'(in_data_i.lun)) * PLANES +
                                        int'(in_data_i.plane_sel));
    cmd_o.req    = (req_in == '0) ? now_in : req_in;
    cmd_o.delay  = cfg_q[delay_sel];
    cmd_o.first  = in_data_i.first_page;
    cmd_o.last   = in_data_i.last_page;
  end

endmodule

@@ design/nplm_back.sv @@
// Back end: plane free-time table, latency arithmetic, running max, output register.
`timescale 1ns / 1ps
module nplm_back #(
  parameter int unsigned PLANE_COUNT = 64,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nplm_pkg::cmd_t          head_i,
  input  nplm_pkg::queue_status_t queue_status_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output nplm_pkg::out_t          out_data_o
);

  localparam int unsigned AddrW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_SPARE = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [AddrW-1:0]       clr_cnt_q, clr_cnt_d;
  nplm_pkg::cmd_t         cmd_q;
  logic [TIME_BITS-1:0]   done_q, done_d;
  logic [TIME_BITS-1:0]   run_max_q, run_max_d;
  logic                   out_valid_q, out_valid_d;
  nplm_pkg::out_t         out_q, out_d;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [TIME_BITS-1:0]   ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0]   req_t, start_t, lat, max_base;
  logic                   out_free;

  nplm_ram #(
    .Width(TIME_BITS),
    .Depth(PLANE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_t      = TIME_BITS'(cmd_q.req);
  assign start_t    = (ram_rdata < req_t) ? req_t : ram_rdata;
  assign done_d     = start_t + TIME_BITS'(cmd_q.delay);
  assign lat        = cmd_q.active ? (done_q - req_t) : '0;
  assign max_base   = cmd_q.first ? '0 : run_max_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign clearing_o = (state_q == ST_CLEAR);
  assign ram_raddr  = head_i.idx[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    run_max_d   = run_max_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cmd_q.idx[AddrW-1:0];
    ram_wdata   = done_d;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(PLANE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!queue_status_i.empty) begin
          pop_o   = 1'b1;
          state_d = head_i.active ? ST_CALC : ST_FIN;
        end
      end
      ST_CALC: begin
        ram_we  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          run_max_d                 = (lat > max_base) ? lat : max_base;
          out_valid_d               = 1'b1;
          out_d.latency             = nplm_pkg::FIELD_TIME_W'(lat);
          out_d.request_max_latency = nplm_pkg::FIELD_TIME_W'(run_max_d);
          out_d.request_done        = cmd_q.last;
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      run_max_q   <= run_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (state_q == ST_CALC) begin
      done_q <= done_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/nand_plane_latency_model.sv @@
// NAND plane latency model: top level joining front end, command queue and back end.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one page operation
//   per transfer. Output channel (out_valid_o / out_stall_i / out_data_o) returns one
//   result per input, in order. Delay registers are written on cfg_we_i with
//   cfg_index_i / cfg_data_i; the user must write only while idle, it is not enforced.
//   Path: an accepted transfer passes the queue, the plane table read, then the
//   latency and running max stage, before its result is registered at the output.
//   Pacing: the back end takes a new page only once it is done with the last; a
//   real operation passes calc and finish, a no-op or out-of-range address only
//   finish, for the read-modify-write of the plane free-time table in the back end.
//   The two-entry queue lets the front accept up to two pages while the back works
//   or while the output register waits on out_stall_i; the output register holds
//   its result unchanged while stalled.
//   Reset: delay registers return to their defaults, the running max clears, and
//   the plane table is cleared one entry per cycle, all CHANNELS*LUNS*PLANES entries
//   (64 by default), during which in_stall_o is high.
`timescale 1ns / 1ps
module nand_plane_latency_model #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned LUNS      = 4,
  parameter int unsigned PLANES    = 2,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nplm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nplm_pkg::DELAY_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nplm_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nplm_pkg::out_t                 out_data_o
);

  localparam int unsigned PlaneCount = CHANNELS * LUNS * PLANES;

  nplm_pkg::cmd_t          push_cmd, head_cmd;
  nplm_pkg::queue_status_t q_status;
  logic                    push, pop, clearing;

  nplm_front #(
    .CHANNELS (CHANNELS),
    .LUNS     (LUNS),
    .PLANES   (PLANES),
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .clearing_i    (clearing),
    .queue_status_i(q_status),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  nplm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  nplm_back #(
    .PLANE_COUNT(PlaneCount),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .queue_status_i(q_status),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

@@ tb/nand_plane_latency_model_test.sv @@
// Self-checking testbench: page traffic against a plane free-time predictor.
`timescale 1ns / 1ps
module nand_plane_latency_model_test;
  import nplm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam logic [FIELD_TIME_W-1:0] T_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DELAY_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  nand_plane_latency_model u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [DELAY_W-1:0] delay_cfg [NUM_REGS];
  logic [FIELD_TIME_W-1:0] plane_free [64];
  logic [FIELD_TIME_W-1:0] req_max;

  in_t pages_to_send [$];
  out_t lat_expect_q [$];
  out_t want;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;
  logic [FIELD_TIME_W-1:0] host_now = 48'd1000;

  initial begin
    for (int i = 0; i < NUM_REGS; i++) delay_cfg[i] = CFG_RESET[i];
    for (int i = 0; i < 64; i++) plane_free[i] = '0;
    req_max = '0;
  end

  function automatic out_t plane_timing(in_t pg);
    logic [FIELD_TIME_W-1:0] req;
    logic [FIELD_TIME_W-1:0] start;
    logic [FIELD_TIME_W-1:0] done;
    logic [5:0] slot;
    cfg_reg_e sel;
    out_t r;
    r = '0;
    req = (pg.request_time == '0) ? pg.current_time : pg.request_time;
    if (pg.op != OP_NONE) begin
      slot = {pg.channel, pg.lun, pg.plane_sel};
      case (pg.op)
        OP_READ:  sel = pg.cell_type ? REG_READ1 : REG_READ0;
        OP_WRITE: sel = pg.cell_type ? REG_WRITE1 : REG_WRITE0;
        default:  sel = pg.cell_type ? REG_ERASE1 : REG_ERASE0;
      endcase
      start = (plane_free[slot] < req) ? req : plane_free[slot];
      done = start + {24'd0, delay_cfg[sel]};
      plane_free[slot] = done;
      r.latency = done - req;
    end
    if (pg.first_page) req_max = '0;
    if (r.latency > req_max) req_max = r.latency;
    r.request_max_latency = req_max;
    r.request_done = pg.last_page;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [FIELD_TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[FIELD_TIME_W-1:0];
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) lat_expect_q.push_back(plane_timing(in_data_i));
      if (in_valid_i && in_stall_o) begin
        // payload held until the transfer happens
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pages_to_send.size() != 0) begin
        in_data_i <= pages_to_send.pop_front();
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (lat_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
        end else begin
          want = lat_expect_q.pop_front();
          if (out_data_o.latency !== want.latency) begin
            mismatches++;
            $display("%0t: latency expected %h actual %h", $time, want.latency,
                     out_data_o.latency);
          end
          if (out_data_o.request_max_latency !== want.request_max_latency) begin
            mismatches++;
            $display("%0t: request_max_latency expected %h actual %h", $time,
                     want.request_max_latency, out_data_o.request_max_latency);
          end
          if (out_data_o.request_done !== want.request_done) begin
            mismatches++;
            $display("%0t: request_done expected %b actual %b", $time, want.request_done,
                     out_data_o.request_done);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < NUM_REGS) delay_cfg[idx] = val;
  endtask

  task automatic add_page(input op_e op, input logic [2:0] ch, input logic [1:0] lun,
                          input logic pl, input logic cell_sel,
                          input logic [FIELD_TIME_W-1:0] req,
                          input logic [FIELD_TIME_W-1:0] now,
                          input logic first, input logic last);
    in_t pg;
    pg.op = op;
    pg.channel = ch;
    pg.lun = lun;
    pg.plane_sel = pl;
    pg.cell_type = cell_sel;
    pg.request_time = req;
    pg.current_time = now;
    pg.first_page = first;
    pg.last_page = last;
    pages_to_send.push_back(pg);
  endtask

  // Mostly host requests of a few pages; about one draw in ten is a single stray noise page.
  task automatic queue_random(input int unsigned count);
    int unsigned left;
    int unsigned len;
    in_t pg;
    in_t base;
    left = count;
    while (left != 0) begin
      if ($urandom_range(9) == 0) begin
        pg.op = op_e'($urandom_range(3));
        pg.channel = 3'($urandom_range(7));
        pg.lun = 2'($urandom_range(3));
        pg.plane_sel = 1'($urandom_range(1));
        pg.cell_type = 1'($urandom_range(1));
        pg.request_time = ($urandom_range(3) == 0) ? '0 : rand48();
        pg.current_time = rand48();
        pg.first_page = 1'($urandom_range(1));
        pg.last_page = 1'($urandom_range(1));
        pages_to_send.push_back(pg);
        left--;
      end else begin
        len = $urandom_range(6, 1);
        if (len > left) len = left;
        base.channel = 3'($urandom_range(7));
        base.lun = 2'($urandom_range(3));
        base.plane_sel = 1'($urandom_range(1));
        base.cell_type = 1'($urandom_range(1));
        for (int k = 0; k < len; k++) begin
          pg = base;
          pg.op = ($urandom_range(11) == 0) ? OP_NONE : op_e'($urandom_range(2));
          if ($urandom_range(1)) begin
            pg.channel = 3'($urandom_range(7));
            pg.lun = 2'($urandom_range(3));
            pg.plane_sel = 1'($urandom_range(1));
          end
          host_now += $urandom_range(150000);
          pg.current_time = host_now;
          case ($urandom_range(9))
            0, 1: pg.request_time = '0;
            2: pg.request_time = rand48();
            default: pg.request_time = host_now - $urandom_range(200000);
          endcase
          pg.first_page = (k == 0);
          pg.last_page = (k == len - 1);
          pages_to_send.push_back(pg);
        end
        left -= len;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pages_to_send.size() != 0 || in_valid_i || lat_expect_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    do @(negedge clk_i);
    while (in_stall_o !== 1'b0);

    // reset delays
    add_page(OP_READ,  3'd0, 2'd0, 1'b0, 1'b0, 48'd1000, 48'd0, 1'b1, 1'b0);
    add_page(OP_WRITE, 3'd0, 2'd0, 1'b0, 1'b0, 48'd1000, 48'd0, 1'b0, 1'b0);
    add_page(OP_ERASE, 3'd0, 2'd0, 1'b0, 1'b0, 48'd0, 48'd5000, 1'b0, 1'b1);
    add_page(OP_READ,  3'd7, 2'd3, 1'b1, 1'b1, 48'd2000, 48'd0, 1'b1, 1'b0);
    add_page(OP_WRITE, 3'd7, 2'd3, 1'b1, 1'b1, 48'd0, 48'd0, 1'b0, 1'b0);
    add_page(OP_ERASE, 3'd7, 2'd3, 1'b1, 1'b1, T_MAX, 48'd0, 1'b0, 1'b1);
    add_page(OP_NONE,  3'd7, 2'd3, 1'b1, 1'b1, 48'd100, 48'd100, 1'b1, 1'b1);
    add_page(OP_NONE,  3'd0, 2'd0, 1'b0, 1'b0, 48'd0, T_MAX, 1'b0, 1'b0);
    add_page(OP_READ,  3'd3, 2'd1, 1'b0, 1'b1, 48'd0, T_MAX, 1'b1, 1'b0);
    add_page(OP_WRITE, 3'd4, 2'd2, 1'b1, 1'b0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
             1'b0, 1'b1);
    add_page(OP_ERASE, 3'd2, 2'd1, 1'b0, 1'b0, 48'h0001_0000_0000, 48'd0, 1'b1, 1'b1);
    add_page(OP_READ,  3'd0, 2'd0, 1'b0, 1'b0, 48'd10, 48'd0, 1'b1, 1'b1);
    wait_idle();

    // extreme delays; writes past the last register must change nothing
    write_reg(REG_READ0, '0);
    write_reg(REG_WRITE0, '1);
    write_reg(REG_ERASE0, '1);
    write_reg(REG_READ1, '1);
    write_reg(REG_WRITE1, '0);
    write_reg(REG_ERASE1, '0);
    write_reg(REG_SPARE6, 24'hA5A5A5);
    write_reg(REG_SPARE7, 24'h5A5A5A);
    add_page(OP_READ,  3'd1, 2'd0, 1'b0, 1'b0, 48'd500, 48'd0, 1'b1, 1'b0);
    add_page(OP_WRITE, 3'd1, 2'd0, 1'b0, 1'b0, T_MAX, 48'd0, 1'b0, 1'b0);
    add_page(OP_ERASE, 3'd1, 2'd0, 1'b0, 1'b0, 48'd0, T_MAX, 1'b0, 1'b1);
    add_page(OP_READ,  3'd5, 2'd2, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF0, 48'd0, 1'b1, 1'b0);
    add_page(OP_WRITE, 3'd5, 2'd2, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF0, 48'd0, 1'b0, 1'b0);
    add_page(OP_ERASE, 3'd5, 2'd2, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF0, 48'd0, 1'b0, 1'b1);
    add_page(OP_NONE,  3'd6, 2'd1, 1'b1, 1'b0, 48'd0, 48'd0, 1'b1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (ph)
          0: write_reg(CFG_IDX_W'(i), '1);
          1: write_reg(CFG_IDX_W'(i), '0);
          default:
            write_reg(CFG_IDX_W'(i), ($urandom_range(4) == 0) ? 24'($urandom())
                                                               : 24'($urandom_range(400000)));
        endcase
      end
      no_idle = (ph == 2);
      if (ph == 4) host_now = T_MAX - 48'd2000000;
      queue_random(50);
      if (ph == 3) wait_idle();
      queue_random(50);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/nplm_pkg.sv
design/nplm_ram.sv
design/nplm_queue.sv
design/nplm_front.sv
design/nplm_back.sv
design/nand_plane_latency_model.sv
tb/nand_plane_latency_model_test.sv
